>>> hdl/bezier_nearest_point_search_unit_macros.svh
// Assertion macros used by the checker file of the nearest point search unit.
`ifndef BEZIER_NEAREST_POINT_SEARCH_UNIT_MACROS_SVH
`define BEZIER_NEAREST_POINT_SEARCH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BNPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bnps assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BNPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bnps assertion failed");

`endif

>>> hdl/bnps_pkg.sv
`default_nettype none
package bnps_pkg;

	localparam int COORD_W = 20;
	localparam int T_W = 7;
	localparam int W_W = 19;
	localparam int PROD_W = 40;
	localparam int SUM_W = 42;
	localparam int DIFF_W = 21;
	localparam int SQ_W = 41;
	localparam int DIST_W = 42;
	localparam int RES_W = 24;
	localparam int SNAP_W = 12;
	localparam int SEGOUT_W = 8;
	localparam int FRAC_SHIFT = 18;
	localparam logic [T_W-1:0] T_HALF = 7'd32;
	localparam logic [T_W-1:0] T_ONE = 7'd64;
	localparam logic [RES_W-1:0] LIMIT_RESET = 24'd123904;

	typedef logic signed [COORD_W-1:0] bnps_coord_t;

	// One segment and the click point, held for the whole segment.
	typedef struct packed {
		bnps_coord_t sx;
		bnps_coord_t sy;
		bnps_coord_t c1x;
		bnps_coord_t c1y;
		bnps_coord_t c2x;
		bnps_coord_t c2y;
		bnps_coord_t ex;
		bnps_coord_t ey;
		bnps_coord_t kx;
		bnps_coord_t ky;
	} bnps_geom_t;

	typedef struct packed {
		logic [W_W-1:0] w0;
		logic [W_W-1:0] w1;
		logic [W_W-1:0] w2;
		logic [W_W-1:0] w3;
	} bnps_weights_t;

	typedef struct packed {
		logic           valid;
		logic           keep;
		logic [T_W-1:0] t;
	} bnps_issue_t;

	typedef struct packed {
		logic              valid;
		logic              keep;
		logic [T_W-1:0]    t;
		logic [DIST_W-1:0] dsq;
	} bnps_sample_t;

	// Bernstein weights scaled by 64^3 for t in sixty-fourths.
	function automatic bnps_weights_t bnps_weights(input logic [T_W-1:0] t);
		logic [T_W-1:0] u;
		logic [12:0]    uu;
		logic [12:0]    tt;
		bnps_weights_t  w;
		u = 7'(T_ONE - t);
		uu = 13'(u) * 13'(u);
		tt = 13'(t) * 13'(t);
		w.w0 = 19'(19'(uu) * 19'(u));
		w.w1 = 19'(19'(uu) * 19'(t) * 19'd3);
		w.w2 = 19'(19'(tt) * 19'(u) * 19'd3);
		w.w3 = 19'(19'(tt) * 19'(t));
		return w;
	endfunction

endpackage
`default_nettype wire

>>> hdl/bezier_nearest_point_search_unit.sv
// The five-stage sample evaluator is shared by the coarse and the fine pass.
// Requests are taken only when idle; an unaccepted report stalls only the next report.
// Reset (arst_n low, asynchronous) clears the sequencer, the search state and output valid.
// Reset loads snap_radius 352, so the distance limit starts at 352 squared.
`default_nettype none
module bezier_nearest_point_search_unit #(
	parameter int COARSE_STEPS = 16,
	parameter int FINE_STEPS = 8,
	parameter int MAX_SEGMENTS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [11:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [19:0] start_x,
	input  wire logic [19:0] start_y,
	input  wire logic [19:0] ctrl1_x,
	input  wire logic [19:0] ctrl1_y,
	input  wire logic [19:0] ctrl2_x,
	input  wire logic [19:0] ctrl2_y,
	input  wire logic [19:0] end_x,
	input  wire logic [19:0] end_y,
	input  wire logic [19:0] click_x,
	input  wire logic [19:0] click_y,
	input  wire logic        last_segment,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [7:0]       best_segment,
	output logic [6:0]       best_param,
	output logic [23:0]      best_dist_sq
);
	import bnps_pkg::*;

	// Sample parameters are produced by an incremental quotient and remainder so that
	// t = floor(num / divisor) never needs a divider. All constants here fold at
	// elaboration. The coarse divisor is COARSE_STEPS, the fine one COARSE*FINE.
	localparam int DEN = COARSE_STEPS * FINE_STEPS;
	localparam int QC = 64 / COARSE_STEPS;
	localparam int RC = 64 % COARSE_STEPS;
	localparam int QF = 128 / DEN;
	localparam int RF = 128 % DEN;
	localparam int QS = (64 * FINE_STEPS) / DEN;
	localparam int RS = (64 * FINE_STEPS) % DEN;
	localparam int QS_ADJ = QS + ((RS != 0) ? 1 : 0);
	localparam int RS_INIT = (RS != 0) ? (DEN - RS) : 0;
	localparam int MAXS = (COARSE_STEPS > FINE_STEPS) ? COARSE_STEPS : FINE_STEPS;
	localparam int CNT_W = $clog2(MAXS + 2);
	localparam int R_W = $clog2(2 * DEN + 1);
	localparam int SEG_W = $clog2(MAX_SEGMENTS);
	localparam int TQ_W = 8;

	// The sequencer walks through the coarse pass, a decision cycle, an optional
	// fine pass and a closing cycle that updates the segment count and the result.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_COARSE = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_FINE   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t              state_q;
	bnps_geom_t          geom_q;
	logic                last_q;
	logic [TQ_W-1:0]     tq_q;
	logic [R_W-1:0]      r_q;
	logic [CNT_W-1:0]    iss_cnt_q;
	logic [CNT_W-1:0]    rcv_cnt_q;
	logic [RES_W-1:0]    seg_best_q;
	logic [CNT_W-1:0]    best_s_q;
	logic                best_hit_q;
	logic [T_W-1:0]      t0_q;
	logic [RES_W-1:0]    run_dist_q;
	logic                run_found_q;
	logic [SEGOUT_W-1:0] run_seg_q;
	logic [T_W-1:0]      run_param_q;
	logic [SEG_W-1:0]    seg_cnt_q;
	logic [SEG_W-1:0]    cur_seg_q;
	logic                open_q;
	logic [RES_W-1:0]    limit_q;
	logic                out_valid_q;
	logic                found_q;
	logic [SEGOUT_W-1:0] best_segment_q;
	logic [T_W-1:0]      best_param_q;
	logic [RES_W-1:0]    best_dist_q;

	bnps_issue_t         issue;
	bnps_sample_t        sample;
	logic                in_take;
	logic                fine_phase;
	logic [CNT_W-1:0]    n_last;
	logic [R_W-1:0]      r_sum;
	logic [R_W-1:0]      r_div;
	logic                r_wrap;
	logic [TQ_W-1:0]     tq_step;
	logic [RES_W-1:0]    cmp_ref;
	logic                nearer;
	logic                interior;
	logic                out_busy;
	logic                report_now;
	logic [SEG_W+SEGOUT_W-1:0] cur_seg_ext;
	logic [SEGOUT_W-1:0] cur_seg8;

	assign in_ready = (state_q == ST_IDLE);
	assign in_take = in_valid && in_ready;
	assign fine_phase = (state_q == ST_FINE);
	assign n_last = fine_phase ? CNT_W'(FINE_STEPS) : CNT_W'(COARSE_STEPS);
	assign out_busy = out_valid_q && !out_ready;
	assign report_now = (state_q == ST_FINISH) && last_q && !out_busy;
	assign cur_seg_ext = {{SEGOUT_W{1'b0}}, cur_seg_q};
	assign cur_seg8 = cur_seg_ext[SEGOUT_W-1:0];

	// Next sample parameter: quotient step plus a carry from the remainder.
	always_comb begin
		r_div = fine_phase ? R_W'(DEN) : R_W'(COARSE_STEPS);
		r_sum = r_q + (fine_phase ? R_W'(RF) : R_W'(RC));
		r_wrap = (r_sum >= r_div);
		tq_step = tq_q + (fine_phase ? TQ_W'(QF) : TQ_W'(QC)) + TQ_W'(r_wrap);
	end

	// A fine sample outside 0..64 is still pushed through the evaluator, marked to
	// be ignored, so that the result count stays fixed.
	always_comb begin
		issue.valid = (state_q == ST_COARSE || state_q == ST_FINE) && (iss_cnt_q <= n_last);
		issue.keep = !fine_phase || (!tq_q[TQ_W-1] && (tq_q[T_W-1:0] <= T_ONE));
		issue.t = tq_q[T_W-1:0];
	end

	// One comparator serves both passes: the coarse pass compares against the
	// best of this segment, the fine pass against the best of the whole search.
	assign cmp_ref = fine_phase ? run_dist_q : seg_best_q;
	assign nearer = sample.dsq < DIST_W'(cmp_ref);
	assign interior = best_hit_q && (best_s_q != '0) && (best_s_q != CNT_W'(COARSE_STEPS));

	bnps_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.geom   (geom_q),
		.issue  (issue),
		.sample (sample)
	);

	// The distance limit is kept squared; a write lands right away, so a search
	// in progress sees the new coarse limit on its next segment.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= RES_W'(cfg_wdata) * RES_W'(cfg_wdata);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			geom_q.sx <= start_x;
			geom_q.sy <= start_y;
			geom_q.c1x <= ctrl1_x;
			geom_q.c1y <= ctrl1_y;
			geom_q.c2x <= ctrl2_x;
			geom_q.c2y <= ctrl2_y;
			geom_q.ex <= end_x;
			geom_q.ey <= end_y;
			geom_q.kx <= click_x;
			geom_q.ky <= click_y;
			last_q <= last_segment;
		end
	end

	// The report register raises valid when a search closes and drops it once
	// the report has been taken; a new report may follow in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report_now) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tq_q <= '0;
			r_q <= '0;
			iss_cnt_q <= '0;
			rcv_cnt_q <= '0;
			seg_best_q <= '0;
			best_s_q <= '0;
			best_hit_q <= 1'b0;
			t0_q <= T_HALF;
			run_dist_q <= LIMIT_RESET;
			run_found_q <= 1'b0;
			run_seg_q <= '0;
			run_param_q <= T_HALF;
			seg_cnt_q <= '0;
			cur_seg_q <= '0;
			open_q <= 1'b0;
			found_q <= 1'b0;
			best_segment_q <= '0;
			best_param_q <= '0;
			best_dist_q <= '0;
		end else begin
			if (issue.valid) begin
				iss_cnt_q <= iss_cnt_q + CNT_W'(1);
				tq_q <= tq_step;
				r_q <= r_wrap ? (r_sum - r_div) : r_sum;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						// The first segment of a search reloads the running best.
						if (!open_q) begin
							run_dist_q <= limit_q;
							run_found_q <= 1'b0;
							run_seg_q <= '0;
							run_param_q <= T_HALF;
							cur_seg_q <= '0;
						end else begin
							cur_seg_q <= seg_cnt_q;
						end
						open_q <= 1'b1;
						tq_q <= '0;
						r_q <= '0;
						iss_cnt_q <= '0;
						rcv_cnt_q <= '0;
						seg_best_q <= limit_q;
						best_s_q <= '0;
						best_hit_q <= 1'b0;
						t0_q <= T_HALF;
						state_q <= ST_COARSE;
					end
				end
				ST_COARSE: begin
					if (sample.valid) begin
						rcv_cnt_q <= rcv_cnt_q + CNT_W'(1);
						if (nearer) begin
							seg_best_q <= sample.dsq[RES_W-1:0];
							best_s_q <= rcv_cnt_q;
							best_hit_q <= 1'b1;
							t0_q <= sample.t;
						end
						if (rcv_cnt_q == n_last) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					state_q <= ST_FINISH;
					if (seg_best_q < run_dist_q) begin
						if (interior) begin
							// The fine pass spans one coarse step either side of t0.
							tq_q <= TQ_W'(t0_q) - TQ_W'(QS_ADJ);
							r_q <= R_W'(RS_INIT);
							iss_cnt_q <= '0;
							rcv_cnt_q <= '0;
							state_q <= ST_FINE;
						end else begin
							// An end point, or no sample inside the limit at all,
							// takes the coarse result as it stands.
							run_dist_q <= seg_best_q;
							run_found_q <= 1'b1;
							run_seg_q <= cur_seg8;
							run_param_q <= t0_q;
						end
					end
				end
				ST_FINE: begin
					if (sample.valid) begin
						rcv_cnt_q <= rcv_cnt_q + CNT_W'(1);
						if (sample.keep && nearer) begin
							run_dist_q <= sample.dsq[RES_W-1:0];
							run_found_q <= 1'b1;
							run_seg_q <= cur_seg8;
							run_param_q <= sample.t;
						end
						if (rcv_cnt_q == n_last) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (!last_q) begin
						seg_cnt_q <= (cur_seg_q == SEG_W'(MAX_SEGMENTS - 1)) ? '0
							: cur_seg_q + SEG_W'(1);
						state_q <= ST_IDLE;
					end else if (!out_busy) begin
						// Report the search and clear it for the next one.
						found_q <= run_found_q;
						best_segment_q <= run_found_q ? run_seg_q : '0;
						best_param_q <= run_found_q ? run_param_q : '0;
						best_dist_q <= run_found_q ? run_dist_q : '0;
						open_q <= 1'b0;
						run_found_q <= 1'b0;
						run_seg_q <= '0;
						run_param_q <= T_HALF;
						run_dist_q <= limit_q;
						seg_cnt_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign best_segment = best_segment_q;
	assign best_param = best_param_q;
	assign best_dist_sq = best_dist_q;

endmodule
`default_nettype wire

>>> hdl/bnps_eval.sv
`default_nettype none
// Five-stage curve sample evaluator: weights, products, point and offset,
// squares, squared distance. One sample may enter every cycle.
module bnps_eval (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bnps_pkg::bnps_geom_t  geom,
	input  wire bnps_pkg::bnps_issue_t issue,
	output bnps_pkg::bnps_sample_t     sample
);
	import bnps_pkg::*;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                     keep_s1, keep_s2, keep_s3, keep_s4, keep_s5;
	logic [T_W-1:0]           t_s1, t_s2, t_s3, t_s4, t_s5;
	bnps_weights_t            w_s1;
	logic signed [PROD_W-1:0] px_s2 [4];
	logic signed [PROD_W-1:0] py_s2 [4];
	logic signed [DIFF_W-1:0] dx_s3, dy_s3;
	logic [SQ_W-1:0]          sqx_s4, sqy_s4;
	logic [DIST_W-1:0]        dsq_s5;

	logic signed [COORD_W:0]  ws [4];
	logic signed [PROD_W-1:0] px [4];
	logic signed [PROD_W-1:0] py [4];
	logic signed [SUM_W-1:0]  sum_x, sum_y, sh_x, sh_y;
	logic signed [DIFF_W-1:0] dx, dy;
	logic signed [SUM_W-1:0]  sqx, sqy;

	always_comb begin
		ws[0] = $signed({2'b00, w_s1.w0});
		ws[1] = $signed({2'b00, w_s1.w1});
		ws[2] = $signed({2'b00, w_s1.w2});
		ws[3] = $signed({2'b00, w_s1.w3});
		px[0] = geom.sx * ws[0];
		px[1] = geom.c1x * ws[1];
		px[2] = geom.c2x * ws[2];
		px[3] = geom.ex * ws[3];
		py[0] = geom.sy * ws[0];
		py[1] = geom.c1y * ws[1];
		py[2] = geom.c2y * ws[2];
		py[3] = geom.ey * ws[3];
	end

	always_comb begin
		sum_x = px_s2[0] + px_s2[1] + px_s2[2] + px_s2[3];
		sum_y = py_s2[0] + py_s2[1] + py_s2[2] + py_s2[3];
		// Arithmetic shift rounds toward minus infinity.
		sh_x = sum_x >>> FRAC_SHIFT;
		sh_y = sum_y >>> FRAC_SHIFT;
		dx = sh_x[DIFF_W-1:0] - {geom.kx[COORD_W-1], geom.kx};
		dy = sh_y[DIFF_W-1:0] - {geom.ky[COORD_W-1], geom.ky};
		sqx = dx_s3 * dx_s3;
		sqy = dy_s3 * dy_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		keep_s1 <= issue.keep;
		t_s1 <= issue.t;
		w_s1 <= bnps_weights(issue.t);
		keep_s2 <= keep_s1;
		t_s2 <= t_s1;
		px_s2 <= px;
		py_s2 <= py;
		keep_s3 <= keep_s2;
		t_s3 <= t_s2;
		dx_s3 <= dx;
		dy_s3 <= dy;
		keep_s4 <= keep_s3;
		t_s4 <= t_s3;
		sqx_s4 <= sqx[SQ_W-1:0];
		sqy_s4 <= sqy[SQ_W-1:0];
		keep_s5 <= keep_s4;
		t_s5 <= t_s4;
		dsq_s5 <= DIST_W'(sqx_s4) + DIST_W'(sqy_s4);
	end

	assign sample.valid = v_s5;
	assign sample.keep = keep_s5;
	assign sample.t = t_s5;
	assign sample.dsq = dsq_s5;

endmodule
`default_nettype wire

>>> hdl/bnps_checker.sv
`default_nettype none
`include "bezier_nearest_point_search_unit_macros.svh"
// Port-level checks on the nearest point search unit.
module bnps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        found,
	input wire logic [7:0]  best_segment,
	input wire logic [6:0]  best_param,
	input wire logic [23:0] best_dist_sq
);

	`BNPS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({found, best_segment, best_param, best_dist_sq}))

	`BNPS_ASSERT_NOW(a_miss_zero, clk, arst_n, out_valid && !found, best_segment == 8'd0 && best_param == 7'd0 && best_dist_sq == 24'd0)

	`BNPS_ASSERT_NOW(a_param_range, clk, arst_n, out_valid && found, best_param <= 7'd64)

	`BNPS_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind bezier_nearest_point_search_unit bnps_checker u_bnps_checker (.*);
`default_nettype wire

>>> verif/bezier_nearest_point_search_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for the nearest point search unit.
//
// Each request is one cubic segment plus a click point. A driver pulls
// requests from a queue and presents them in bursts with random gaps. The
// stimulus is a directed opening followed by random searches, with a
// snap_radius write between phases. A behavioral predictor computes the
// search report that each closing request should produce. A monitor with its
// own stall pattern compares every report field by field against the oldest
// prediction.
module bezier_nearest_point_search_unit_tb;
	import bnps_pkg::*;

	localparam int COARSE = 16;
	localparam int FINE = 8;
	localparam int SEG_WRAP = 256;
	localparam int DRAIN_CYCLES = 64;
	localparam int COORD_MAX = 524287;
	localparam int COORD_MIN = -524288;

	// One segment request, laid out so that the driver can hand its fields to the ports.
	typedef struct packed {
		bnps_coord_t sx, sy, c1x, c1y, c2x, c2y, ex, ey, kx, ky;
		logic        last;
	} segment_req_t;

	// One search report as the unit presents it.
	typedef struct packed {
		logic              found;
		logic [7:0]        segment;
		logic [T_W-1:0]    param;
		logic [RES_W-1:0]  dist_sq;
	} search_report_t;

	// The receiver moves between three moods to put stalls on every phase of a report.
	typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_STARVED} rx_pattern_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [SNAP_W-1:0]   cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	segment_req_t        drv_req = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                found;
	logic [7:0]          best_segment;
	logic [6:0]          best_param;
	logic [23:0]         best_dist_sq;

	segment_req_t        segment_queue[$];
	search_report_t      expected_reports[$];
	int                  reqs_outstanding = 0;
	int                  fail_count = 0;

	// Predictor copy of the register and of the search state.
	logic [SNAP_W-1:0]   snap_model = 12'd352;
	logic [RES_W-1:0]    run_dist = LIMIT_RESET;
	logic                run_found = 1'b0;
	logic [7:0]          run_seg = '0;
	logic [T_W-1:0]      run_param = T_HALF;
	logic [7:0]          seg_count = '0;
	logic                search_open = 1'b0;

	int                  click_sel_x;
	int                  click_sel_y;

	int                  burst_left = 1;
	int                  gap_left = 0;
	rx_pattern_t         rx_pattern = RX_OPEN;
	int                  rx_pattern_left = 0;
	search_report_t      report_want;

	bezier_nearest_point_search_unit #(
		.COARSE_STEPS(COARSE),
		.FINE_STEPS(FINE),
		.MAX_SEGMENTS(SEG_WRAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_x(drv_req.sx),
		.start_y(drv_req.sy),
		.ctrl1_x(drv_req.c1x),
		.ctrl1_y(drv_req.c1y),
		.ctrl2_x(drv_req.c2x),
		.ctrl2_y(drv_req.c2y),
		.end_x(drv_req.ex),
		.end_y(drv_req.ey),
		.click_x(drv_req.kx),
		.click_y(drv_req.ky),
		.last_segment(drv_req.last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.best_segment(best_segment),
		.best_param(best_param),
		.best_dist_sq(best_dist_sq)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Cubic Bernstein blend at t in sixty-fourths. The arithmetic right shift
	// of a signed value rounds toward minus infinity, as the unit does.
	function automatic longint curve_point(longint p0, longint p1, longint p2, longint p3,
			longint t);
		longint u;
		u = 64 - t;
		return (p0 * u * u * u + 3 * p1 * u * u * t + 3 * p2 * u * t * t + p3 * t * t * t)
			>>> FRAC_SHIFT;
	endfunction

	function automatic longint sample_dist_sq(segment_req_t r, longint t);
		longint dx;
		longint dy;
		dx = curve_point(r.sx, r.c1x, r.c2x, r.ex, t) - r.kx;
		dy = curve_point(r.sy, r.c1y, r.c2y, r.ey, t) - r.ky;
		return dx * dx + dy * dy;
	endfunction

	// Folds one accepted segment into the running search. A closing segment
	// queues the report the unit owes and reopens the search state.
	task automatic predict_segment(input segment_req_t r);
		longint          limit;
		longint          seg_min;
		longint          d;
		longint          t;
		longint          t_best;
		longint          num;
		int              best_idx;
		int              s;
		logic [7:0]      seg;
		search_report_t  rep;
		limit = longint'(snap_model) * longint'(snap_model);
		seg_min = limit;
		best_idx = -1;
		t_best = 32;
		seg = seg_count;
		// The first segment of a search picks up whatever radius is set now.
		if (!search_open) begin
			run_dist = RES_W'(limit);
			run_found = 1'b0;
			run_seg = '0;
			run_param = T_HALF;
			seg = '0;
			search_open = 1'b1;
		end
		// The coarse pass is held against the per-segment limit, which always
		// tracks the current register value.
		for (s = 0; s <= COARSE; s++) begin
			t = (longint'(s) * 64) / COARSE;
			d = sample_dist_sq(r, t);
			if (d < seg_min) begin
				seg_min = d;
				best_idx = s;
				t_best = t;
			end
		end
		if (seg_min < longint'(run_dist)) begin
			if (best_idx > 0 && best_idx < COARSE) begin
				// Interior coarse hit: scan one coarse step either side, each
				// sample competing with the best of the whole search.
				for (s = 0; s <= FINE; s++) begin
					num = t_best * COARSE * FINE - 64 * FINE + 128 * s;
					if (num >= 0) begin
						t = num / (COARSE * FINE);
						if (t <= 64) begin
							d = sample_dist_sq(r, t);
							if (d < longint'(run_dist)) begin
								run_dist = RES_W'(d);
								run_found = 1'b1;
								run_seg = seg;
								run_param = T_W'(t);
							end
						end
					end
				end
			end else begin
				// Endpoint hit, or no coarse hit at all: no refinement, the coarse sample stands.
				run_dist = RES_W'(seg_min);
				run_found = 1'b1;
				run_seg = seg;
				run_param = T_W'(t_best);
			end
		end
		seg_count = 8'((int'(seg) + 1) % SEG_WRAP);
		if (r.last) begin
			if (run_found) begin
				rep = '{found: 1'b1, segment: run_seg, param: run_param, dist_sq: run_dist};
			end else begin
				rep = '0;
			end
			expected_reports = {expected_reports, rep};
			search_open = 1'b0;
			run_found = 1'b0;
			run_seg = '0;
			run_param = T_HALF;
			run_dist = RES_W'(limit);
			seg_count = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------

	// A request stays on the ports until it is taken. Once taken, the next one
	// goes out at once unless the current burst has run out, in which case a
	// random gap follows. A quarter of the gaps are zero, so long unbroken
	// streams happen too.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_segment(drv_req);
				reqs_outstanding--;
			end
			if (!(in_valid && !in_ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (segment_queue.size() > 0) begin
					drv_req <= segment_queue.pop_front();
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Report monitor
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_pattern_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("search report with no request pending: found %0d segment %0d",
						found, best_segment);
					fail_count++;
				end else begin
					report_want = expected_reports.pop_front();
					check_field("found", 24'(report_want.found), 24'(found));
					check_field("best_segment", 24'(report_want.segment), 24'(best_segment));
					check_field("best_param", 24'(report_want.param), 24'(best_param));
					check_field("best_dist_sq", report_want.dist_sq, best_dist_sq);
				end
			end
			if (rx_pattern_left == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 2));
				rx_pattern_left = $urandom_range(20, 200);
			end
			rx_pattern_left--;
			case (rx_pattern)
				RX_OPEN: begin
					out_ready <= 1'b1;
				end
				RX_CHOPPY: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					out_ready <= ($urandom_range(0, 7) == 0);
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic bnps_coord_t clamp_coord(int v);
		if (v > COORD_MAX)
			return bnps_coord_t'(COORD_MAX);
		if (v < COORD_MIN)
			return bnps_coord_t'(COORD_MIN);
		return bnps_coord_t'(v);
	endfunction

	function automatic int jitter(int spread);
		return int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	function automatic segment_req_t make_segment(int sx, int sy, int c1x, int c1y, int c2x,
			int c2y, int ex, int ey, int kx, int ky, bit close);
		segment_req_t r;
		r.sx = clamp_coord(sx);
		r.sy = clamp_coord(sy);
		r.c1x = clamp_coord(c1x);
		r.c1y = clamp_coord(c1y);
		r.c2x = clamp_coord(c2x);
		r.c2y = clamp_coord(c2y);
		r.ex = clamp_coord(ex);
		r.ey = clamp_coord(ey);
		r.kx = clamp_coord(kx);
		r.ky = clamp_coord(ky);
		r.last = close;
		return r;
	endfunction

	// Straight segment with its control points on the chord.
	function automatic segment_req_t line_segment(int ax, int ay, int bx, int by, int kx,
			int ky, bit close);
		return make_segment(ax, ay, ax + (bx - ax) / 3, ay + (by - ay) / 3,
			ax + 2 * (bx - ax) / 3, ay + 2 * (by - ay) / 3, bx, by, kx, ky, close);
	endfunction

	// Control points scattered in a box around the click point.
	function automatic segment_req_t segment_near(int kx, int ky, int spread);
		return make_segment(kx + jitter(spread), ky + jitter(spread), kx + jitter(spread),
			ky + jitter(spread), kx + jitter(spread), ky + jitter(spread),
			kx + jitter(spread), ky + jitter(spread), kx, ky, 1'b0);
	endfunction

	// Every field random over its full range, click point included.
	function automatic segment_req_t noise_segment();
		logic [223:0] bits;
		segment_req_t r;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = bits[$bits(segment_req_t)-1:0];
		return r;
	endfunction

	task automatic add_request(input segment_req_t r);
		segment_queue = {segment_queue, r};
		reqs_outstanding++;
	endtask

	task automatic pick_click();
		if ($urandom_range(0, 7) == 0) begin
			click_sel_x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			click_sel_y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		end else begin
			click_sel_x = int'(bnps_coord_t'($urandom));
			click_sel_y = int'(bnps_coord_t'($urandom));
		end
	endtask

	// Mostly segments close to the click, some wider, a few far away and a
	// sprinkle of pure noise. Only a closing search marks its last segment.
	task automatic queue_search(input int segments, input int spread, input bit close);
		segment_req_t r;
		int           i;
		int           pick;
		for (i = 0; i < segments; i++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				r = noise_segment();
			else if (pick < 12)
				r = segment_near(click_sel_x, click_sel_y, spread);
			else if (pick < 17)
				r = segment_near(click_sel_x, click_sel_y, spread * 6);
			else
				r = segment_near(click_sel_x, click_sel_y, 40000);
			r.last = close && (i == segments - 1);
			add_request(r);
		end
	endtask

	task automatic random_searches(input int count);
		int queued;
		int segments;
		int spread;
		queued = 0;
		while (queued < count) begin
			segments = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12)
				: $urandom_range(1, 4);
			case ($urandom_range(0, 3))
				0: spread = 40;
				1: spread = 300;
				2: spread = 1200;
				default: spread = 4000;
			endcase
			pick_click();
			queue_search(segments, spread, 1'b1);
			queued += segments;
		end
	endtask

	// The sender holds off here until every request has been taken and every
	// report has come back, then gives the unit time to finish any segment
	// that closes no search.
	task automatic wait_idle();
		while (reqs_outstanding != 0 || expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only while the unit is idle, so the predictor
	// takes the new value at the same edge.
	task automatic write_snap_radius(input logic [SNAP_W-1:0] radius);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= radius;
		snap_model = radius;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		int           kx;
		int           ky;
		int           i;
		segment_req_t twin;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening at the reset radius. The click stays clear of the
		// coordinate limits so that the offsets below are not clamped.
		kx = int'($urandom_range(0, 800000)) - 400000;
		ky = int'($urandom_range(0, 800000)) - 400000;
		// Curve collapsed onto the click point: exact hit at t = 0.
		add_request(make_segment(kx, ky, kx, ky, kx, ky, kx, ky, kx, ky, 1'b1));
		// Only the end point comes close, so the coarse sample at t = 64 stands.
		add_request(make_segment(kx + 5000, ky, kx + 4000, ky + 800, kx + 2000, ky - 900,
			kx + 3, ky + 4, kx, ky, 1'b1));
		// A chord passing just past the click, slightly off center, gets refined.
		add_request(line_segment(kx - 1990, ky + 10, kx + 2010, ky + 10, kx, ky, 1'b1));
		// Nothing inside the radius: the report comes back all zero.
		add_request(line_segment(kx + 90000, ky, kx + 95000, ky + 3000, kx, ky, 1'b1));
		// Coordinate extremes, with and without a hit.
		add_request(make_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1));
		add_request(make_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1));
		add_request(make_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
		add_request(make_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
			COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
		// Five-segment search where the middle segment runs through the click.
		add_request(line_segment(kx + 60000, ky, kx + 64000, ky, kx, ky, 1'b0));
		add_request(line_segment(kx - 2000, ky + 100, kx + 2000, ky + 100, kx, ky, 1'b0));
		add_request(line_segment(kx - 2000, ky, kx + 2000, ky, kx, ky, 1'b0));
		add_request(line_segment(kx - 2000, ky - 50, kx + 2000, ky - 50, kx, ky, 1'b0));
		add_request(line_segment(kx - 70000, ky, kx - 66000, ky, kx, ky, 1'b1));
		// Identical segments tie; the comparison is strict, so the first wins.
		twin = segment_near(kx, ky, 200);
		add_request(twin);
		twin.last = 1'b1;
		add_request(twin);
		// Chained segments sharing the click as a joint: the earlier end point wins.
		add_request(line_segment(kx - 3000, ky + 7, kx, ky, kx, ky, 1'b0));
		add_request(line_segment(kx, ky, kx + 3000, ky - 7, kx, ky, 1'b1));
		wait_idle();

		// A zero radius admits nothing.
		write_snap_radius(12'd0);
		random_searches(80);
		wait_idle();

		// Widest radius: most searches find something.
		write_snap_radius(12'hFFF);
		random_searches(200);
		wait_idle();

		// A radius of one admits exact hits only.
		write_snap_radius(12'd1);
		random_searches(60);
		wait_idle();

		// Radius change in the middle of an open search: the coarse limit
		// moves at once while the running best carries over.
		write_snap_radius(12'd2000);
		pick_click();
		queue_search(4, 1500, 1'b0);
		wait_idle();
		write_snap_radius(12'd200);
		queue_search(3, 300, 1'b1);
		wait_idle();

		// A search longer than the segment counter: only segments 10 and 270
		// come near, and the exact hit on 270 reports with its index wrapped.
		write_snap_radius(12'd352);
		kx = int'($urandom_range(0, 400000)) - 200000;
		ky = int'($urandom_range(0, 400000)) - 200000;
		for (i = 0; i < 300; i++) begin
			if (i == 10)
				add_request(line_segment(kx - 2000, ky + 300, kx + 2000, ky + 300, kx, ky,
					1'b0));
			else if (i == 270)
				add_request(line_segment(kx - 2000, ky, kx + 2000, ky, kx, ky, 1'b0));
			else
				add_request(segment_near(kx + 60000, ky + jitter(20000), 3000));
		end
		add_request(line_segment(kx + 80000, ky, kx + 84000, ky, kx, ky, 1'b1));
		wait_idle();

		// Random radii for the bulk of the run.
		repeat (3) begin
			write_snap_radius(SNAP_W'($urandom_range(0, 4095)));
			random_searches(80);
			wait_idle();
		end

		if (expected_reports.size() != 0) begin
			$error("%0d search reports never arrived", expected_reports.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: ends a run that hangs and reports what is still outstanding.
	initial begin
		#8000000;
		$error("timed out with %0d requests and %0d reports outstanding",
			reqs_outstanding, expected_reports.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bnps_pkg.sv
hdl/bnps_eval.sv
hdl/bezier_nearest_point_search_unit.sv
hdl/bnps_checker.sv
verif/bezier_nearest_point_search_unit_tb.sv
